// File: rtl/dro_pkg.sv
package dro_pkg;

  // Codemap storage.
  localparam int CM_DEPTH = 128;
  localparam int CM_AW = (CM_DEPTH > 1) ? $clog2(CM_DEPTH) : 1;

  // Field widths.
  localparam int CMD_W = 2;
  localparam int BYTE_W = 8;
  localparam int IDX_W = 7;
  localparam int DELAY_W = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  // Request commands.
  localparam logic [CMD_W-1:0] CMD_BYTE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HARDWARE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_DELAY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_DELAY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CM_LENGTH = 3'd4;

  // Hardware types.
  localparam logic [7:0] HW_OPL2 = 8'd0;
  localparam logic [7:0] HW_OPL3 = 8'd1;
  localparam logic [7:0] HW_DUAL_OPL2 = 8'd2;

  // Result kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_DELAY = 1'b1;

  typedef struct packed {
    logic               kind;
    logic               chip;
    logic [BYTE_W-1:0]  register_number;
    logic [BYTE_W-1:0]  register_value;
    logic [DELAY_W-1:0] delay_ms;
  } result_t;

endpackage

// File: rtl/dro_if.sv
interface dro_in_if import dro_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] data_byte;
  logic [IDX_W-1:0]  table_index;

  modport source (output valid, command, data_byte, table_index, input ready);
  modport sink (input valid, command, data_byte, table_index, output ready);
endinterface

interface dro_out_if import dro_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic               chip;
  logic [BYTE_W-1:0]  register_number;
  logic [BYTE_W-1:0]  register_value;
  logic [DELAY_W-1:0] delay_ms;

  modport source (output valid, kind, chip, register_number, register_value, delay_ms,
                  input ready);
  modport sink (input valid, kind, chip, register_number, register_value, delay_ms,
                output ready);
endinterface

// File: rtl/dro_command_stream_decoder_unit.sv
// DRO command stream decoder.
// The stream channel takes one request per cycle unless stalled: a stream byte,
// a codemap load, or a parser restart. The result channel gives register writes and
// millisecond delays, at most one per request. Configuration is written
// through cfg_we / cfg_index / cfg_data; the user must do so only while no
// request is in flight, and the block itself does not enforce this. A result
// passes through the read stage (codemap read) and then the output register.
// Throughput: one request per cycle while stream.ready is high.
// The parser state lives in flip-flops; the codemap is a synchronous RAM
// with one write port (loads) and one registered read port (translation).
// A load and a translating read never fall on the same edge, and a read
// always follows every earlier load, so no forwarding is needed.
// When the receiver stalls, one result waits in the output register and
// one more in the read stage; requests that give no result keep flowing,
// and stream.ready drops only while both slots are full.
// Reset (synchronous, active high) returns the configuration to its
// defaults, idles the parser and empties the pipeline; the codemap keeps
// its contents and is undefined until loaded.
module dro_command_stream_decoder_unit import dro_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  dro_in_if.sink                stream,
  dro_out_if.source             result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_DELAY8 = 3'd1;
  localparam logic [2:0] PH_D16_LO = 3'd2;
  localparam logic [2:0] PH_D16_HI = 3'd3;
  localparam logic [2:0] PH_ESCAPE = 3'd4;
  localparam logic [2:0] PH_OLD_VALUE = 3'd5;
  localparam logic [2:0] PH_NEW_VALUE = 3'd6;

  // Configuration.
  logic       format_mode;
  logic [7:0] hardware_type;
  logic [7:0] short_delay_code;
  logic [7:0] long_delay_code;
  logic [7:0] codemap_length;

  // Parser state.
  logic [2:0]        phase, phase_next;
  logic [BYTE_W-1:0] code_latch, code_latch_next;
  logic [BYTE_W-1:0] low_latch, low_latch_next;
  logic              chip_select, chip_select_next;

  // Codemap.
  logic [BYTE_W-1:0] codemap_mem [CM_DEPTH];
  logic [BYTE_W-1:0] cm_rdata;

  // Read stage and output register.
  logic    s1_valid;
  result_t s1_res;
  logic    s1_xlat;
  result_t s1_fwd;
  logic    out_valid;
  result_t out_res;

  logic    accept, s1_load, s1_adv;
  logic    res_v, res_xlat;
  result_t res;
  logic [2:0] ph_eff;
  logic [BYTE_W-1:0] b;

  assign b = stream.data_byte;
  assign s1_adv = !out_valid || result.ready;
  assign stream.ready = !s1_valid || s1_adv;
  assign accept = stream.valid && stream.ready;
  assign s1_load = accept && res_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode <= 1'b0;
      hardware_type <= 8'd0;
      short_delay_code <= 8'd0;
      long_delay_code <= 8'd1;
      codemap_length <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FORMAT: format_mode <= cfg_data[0];
        CFG_HARDWARE: hardware_type <= cfg_data;
        CFG_SHORT_DELAY: short_delay_code <= cfg_data;
        CFG_LONG_DELAY: long_delay_code <= cfg_data;
        CFG_CM_LENGTH: codemap_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next = phase;
    code_latch_next = code_latch;
    low_latch_next = low_latch;
    chip_select_next = chip_select;
    res_v = 1'b0;
    res_xlat = 1'b0;
    res = '0;
    ph_eff = (phase > PH_OLD_VALUE) ? PH_IDLE : phase;
    if (accept) begin
      case (stream.command)
        CMD_RESTART: begin
          phase_next = PH_IDLE;
          code_latch_next = '0;
          low_latch_next = '0;
          chip_select_next = 1'b0;
        end
        CMD_BYTE: begin
          if (format_mode) begin
            if (phase == PH_NEW_VALUE) begin
              phase_next = PH_IDLE;
              if (code_latch == short_delay_code) begin
                res_v = 1'b1;
                res.kind = KIND_DELAY;
                res.delay_ms = DELAY_W'({1'b0, b} + 9'd1);
              end else if (code_latch == long_delay_code) begin
                res_v = 1'b1;
                res.kind = KIND_DELAY;
                res.delay_ms = DELAY_W'({{1'b0, b} + 9'd1, 8'd0});
              end else if (hardware_type <= HW_DUAL_OPL2) begin
                res_v = 1'b1;
                res.kind = KIND_WRITE;
                res.chip = code_latch[7];
                res.register_number = {1'b0, code_latch[6:0]};
                res.register_value = b;
                res_xlat = ({1'b0, code_latch[6:0]} < codemap_length) &&
                           (int'(code_latch[6:0]) < CM_DEPTH);
              end
            end else begin
              code_latch_next = b;
              phase_next = PH_NEW_VALUE;
            end
          end else begin
            case (ph_eff)
              PH_DELAY8: begin
                phase_next = PH_IDLE;
                res_v = 1'b1;
                res.kind = KIND_DELAY;
                res.delay_ms = DELAY_W'({1'b0, b} + 9'd1);
              end
              PH_D16_LO: begin
                low_latch_next = b;
                phase_next = PH_D16_HI;
              end
              PH_D16_HI: begin
                phase_next = PH_IDLE;
                res_v = 1'b1;
                res.kind = KIND_DELAY;
                res.delay_ms = {1'b0, b, low_latch} + DELAY_W'(1);
              end
              PH_ESCAPE: begin
                code_latch_next = b;
                phase_next = PH_OLD_VALUE;
              end
              PH_OLD_VALUE: begin
                phase_next = PH_IDLE;
                res.kind = KIND_WRITE;
                res.register_number = code_latch;
                res.register_value = b;
                if (hardware_type == HW_OPL2) begin
                  res_v = 1'b1;
                end else if (hardware_type == HW_OPL3 || hardware_type == HW_DUAL_OPL2) begin
                  res_v = 1'b1;
                  res.chip = chip_select;
                end
              end
              default: begin
                // Command byte. On a single OPL2 the chip selects are plain registers.
                if (b == 8'd0) begin
                  phase_next = PH_DELAY8;
                end else if (b == 8'd1) begin
                  phase_next = PH_D16_LO;
                end else if (b == 8'd2 && hardware_type != HW_OPL2) begin
                  chip_select_next = 1'b0;
                  phase_next = PH_IDLE;
                end else if (b == 8'd3 && hardware_type != HW_OPL2) begin
                  chip_select_next = 1'b1;
                  phase_next = PH_IDLE;
                end else if (b == 8'd4) begin
                  phase_next = PH_ESCAPE;
                end else begin
                  code_latch_next = b;
                  phase_next = PH_OLD_VALUE;
                end
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      code_latch <= '0;
      low_latch <= '0;
      chip_select <= 1'b0;
    end else begin
      phase <= phase_next;
      code_latch <= code_latch_next;
      low_latch <= low_latch_next;
      chip_select <= chip_select_next;
    end
  end

  // Codemap RAM: load port and registered translation read.
  always_ff @(posedge clk) begin
    if (accept && stream.command == CMD_LOAD && int'(stream.table_index) < CM_DEPTH) begin
      codemap_mem[stream.table_index[CM_AW-1:0]] <= b;
    end
    if (s1_load) begin
      cm_rdata <= codemap_mem[code_latch[CM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_load || (s1_valid && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_res <= res;
      s1_xlat <= res_xlat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_comb begin
    s1_fwd = s1_res;
    if (s1_xlat) begin
      s1_fwd.register_number = cm_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      out_res <= s1_fwd;
    end
  end

  assign result.valid = out_valid;
  assign result.kind = out_res.kind;
  assign result.chip = out_res.chip;
  assign result.register_number = out_res.register_number;
  assign result.register_value = out_res.register_value;
  assign result.delay_ms = out_res.delay_ms;

  // A waiting result in the read stage must not be lost while the output is blocked.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid)
    else $error("read stage dropped a pending result");

  // Delays are never zero, and writes carry no delay.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.kind == KIND_DELAY |-> result.delay_ms != '0)
    else $error("delay result with zero length");

  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.kind == KIND_WRITE |-> result.delay_ms == '0)
    else $error("write result with nonzero delay");

  // A result can only enter the read stage when there is room for it.
  assert property (@(posedge clk) disable iff (rst)
    s1_load |-> !s1_valid || s1_adv)
    else $error("read stage overwritten");

endmodule

// File: bench/dro_decoder_check_pkg.sv
package dro_decoder_check_pkg;
  import dro_pkg::*;

  // Command code that the block ignores.
  localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

  // Old-format command bytes.
  localparam logic [BYTE_W-1:0] OP_DELAY8 = 8'h00;
  localparam logic [BYTE_W-1:0] OP_DELAY16 = 8'h01;
  localparam logic [BYTE_W-1:0] OP_CHIP_LO = 8'h02;
  localparam logic [BYTE_W-1:0] OP_CHIP_HI = 8'h03;
  localparam logic [BYTE_W-1:0] OP_ESCAPE = 8'h04;

  typedef enum logic [2:0] {
    PARSE_IDLE,
    PARSE_DELAY8,
    PARSE_D16_LO,
    PARSE_D16_HI,
    PARSE_ESCAPE,
    PARSE_OLD_VALUE,
    PARSE_NEW_VALUE
  } parse_phase_e;

  class decode_scoreboard;
    logic              new_format;
    logic [7:0]        hw_type;
    logic [7:0]        short_code;
    logic [7:0]        long_code;
    logic [7:0]        map_len;
    parse_phase_e      phase;
    logic [7:0]        code_latch;
    logic [7:0]        low_latch;
    logic              chip_sel;
    logic [7:0]        codemap [CM_DEPTH];
    result_t           pending_events [$];
    int unsigned       mismatches;

    function new();
      new_format = 1'b0;
      hw_type = HW_OPL2;
      short_code = 8'h00;
      long_code = 8'h01;
      map_len = 8'h00;
      phase = PARSE_IDLE;
      code_latch = 8'h00;
      low_latch = 8'h00;
      chip_sel = 1'b0;
      mismatches = 0;
      foreach (codemap[i]) codemap[i] = 8'h00;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FORMAT: new_format = data[0];
        CFG_HARDWARE: hw_type = data;
        CFG_SHORT_DELAY: short_code = data;
        CFG_LONG_DELAY: long_code = data;
        CFG_CM_LENGTH: map_len = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_events.size();
    endfunction

    function void push_write(logic chip, logic [7:0] reg_num, logic [7:0] value);
      result_t ev;
      ev.kind = KIND_WRITE;
      ev.chip = chip;
      ev.register_number = reg_num;
      ev.register_value = value;
      ev.delay_ms = '0;
      pending_events.push_back(ev);
    endfunction

    function void push_delay(logic [DELAY_W-1:0] ms);
      result_t ev;
      ev.kind = KIND_DELAY;
      ev.chip = 1'b0;
      ev.register_number = '0;
      ev.register_value = '0;
      ev.delay_ms = ms;
      pending_events.push_back(ev);
    endfunction

    // Unknown hardware swallows the pair without a write.
    function void old_write(logic [7:0] reg_num, logic [7:0] value);
      if (hw_type == HW_OPL2) begin
        push_write(1'b0, reg_num, value);
      end else if (hw_type == HW_OPL3 || hw_type == HW_DUAL_OPL2) begin
        push_write(chip_sel, reg_num, value);
      end
    endfunction

    function void new_pair(logic [7:0] code, logic [7:0] value);
      logic [7:0] reg_num;
      if (code == short_code) begin
        push_delay({9'd0, value} + 17'd1);
      end else if (code == long_code) begin
        push_delay(({9'd0, value} + 17'd1) << 8);
      end else if (hw_type <= HW_DUAL_OPL2) begin
        reg_num = {1'b0, code[6:0]};
        if (reg_num < map_len) reg_num = codemap[reg_num[6:0]];
        push_write(code[7], reg_num, value);
      end
    endfunction

    function void decode_stream_byte(logic [7:0] b);
      if (new_format) begin
        // A half-parsed old-format item is dropped when the format changes.
        if (phase == PARSE_NEW_VALUE) begin
          phase = PARSE_IDLE;
          new_pair(code_latch, b);
        end else begin
          code_latch = b;
          phase = PARSE_NEW_VALUE;
        end
      end else begin
        case (phase)
          PARSE_DELAY8: begin
            phase = PARSE_IDLE;
            push_delay({9'd0, b} + 17'd1);
          end
          PARSE_D16_LO: begin
            low_latch = b;
            phase = PARSE_D16_HI;
          end
          PARSE_D16_HI: begin
            phase = PARSE_IDLE;
            push_delay({1'b0, b, low_latch} + 17'd1);
          end
          PARSE_ESCAPE: begin
            code_latch = b;
            phase = PARSE_OLD_VALUE;
          end
          PARSE_OLD_VALUE: begin
            phase = PARSE_IDLE;
            old_write(code_latch, b);
          end
          default: begin
            if (b == OP_DELAY8) begin
              phase = PARSE_DELAY8;
            end else if (b == OP_DELAY16) begin
              phase = PARSE_D16_LO;
            end else if (b == OP_CHIP_LO && hw_type != HW_OPL2) begin
              chip_sel = 1'b0;
              phase = PARSE_IDLE;
            end else if (b == OP_CHIP_HI && hw_type != HW_OPL2) begin
              chip_sel = 1'b1;
              phase = PARSE_IDLE;
            end else if (b == OP_ESCAPE) begin
              phase = PARSE_ESCAPE;
            end else begin
              code_latch = b;
              phase = PARSE_OLD_VALUE;
            end
          end
        endcase
      end
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [7:0] b, logic [IDX_W-1:0] idx);
      case (cmd)
        CMD_BYTE: decode_stream_byte(b);
        CMD_LOAD: codemap[idx] = b;
        CMD_RESTART: begin
          phase = PARSE_IDLE;
          code_latch = 8'h00;
          low_latch = 8'h00;
          chip_sel = 1'b0;
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending (kind %0d reg %02h val %02h ms %0d)",
                                  got.kind, got.register_number, got.register_value,
                                  got.delay_ms));
        return;
      end
      want = pending_events.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.chip !== want.chip)
        report_mismatch($sformatf("chip %0d, want %0d", got.chip, want.chip));
      if (got.register_number !== want.register_number)
        report_mismatch($sformatf("register_number %02h, want %02h",
                                  got.register_number, want.register_number));
      if (got.register_value !== want.register_value)
        report_mismatch($sformatf("register_value %02h, want %02h",
                                  got.register_value, want.register_value));
      if (got.delay_ms !== want.delay_ms)
        report_mismatch($sformatf("delay_ms %0d, want %0d", got.delay_ms, want.delay_ms));
    endtask
  endclass

endpackage

// File: bench/dro_command_stream_decoder_unit_tb.sv
module dro_command_stream_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dro_pkg::*;
  import dro_decoder_check_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dro_in_if  stream_if ();
  dro_out_if result_if ();

  dro_command_stream_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .stream    (stream_if),
    .result    (result_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  decode_scoreboard sb = new();

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int stall_asks = 0;
  int requests_sent = 0;

  logic [7:0] phase_hw [12] = '{8'd0, 8'd0, 8'd1, 8'd255, 8'd2, 8'd1,
                                8'd255, 8'd2, 8'd3, 8'd0, 8'd2, 8'd1};
  logic [7:0] phase_len [12] = '{8'd0, 8'd128, 8'd16, 8'd255, 8'd0, 8'd64,
                                 8'd7, 8'd1, 8'd200, 8'd127, 8'd3, 8'd100};

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: random back-pressure, long holds on demand, and checking.
  initial begin
    result_t got;
    int hold_left;
    int stalls_done;
    result_if.ready = 1'b0;
    hold_left = 0;
    stalls_done = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_if.valid && result_if.ready) begin
        got.kind = result_if.kind;
        got.chip = result_if.chip;
        got.register_number = result_if.register_number;
        got.register_value = result_if.register_value;
        got.delay_ms = result_if.delay_ms;
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (stall_asks != stalls_done) begin
        stalls_done++;
        hold_left = 80;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_request(logic [CMD_W-1:0] cmd, logic [7:0] b, logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < src_idle_pct) begin
      stream_if.valid <= 1'b0;
      @(posedge clk);
    end
    stream_if.valid <= 1'b1;
    stream_if.command <= cmd;
    stream_if.data_byte <= b;
    stream_if.table_index <= idx;
    do @(posedge clk); while (!stream_if.ready);
    sb.note_request(cmd, b, idx);
    if (cmd != CMD_IGNORED) requests_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_request(CMD_BYTE, b, 7'($urandom_range(127)));
  endtask

  // Stops offering requests and waits for the pipeline to empty, including
  // requests that produce nothing.
  task automatic drain();
    stream_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, data);
    @(posedge clk);
  endtask

  task automatic apply_settings(logic fmt, logic [7:0] hw, logic [7:0] sc, logic [7:0] lc,
                                logic [7:0] len);
    write_setting(CFG_FORMAT, {7'd0, fmt});
    write_setting(CFG_HARDWARE, hw);
    write_setting(CFG_SHORT_DELAY, sc);
    write_setting(CFG_LONG_DELAY, lc);
    write_setting(CFG_CM_LENGTH, len);
  endtask

  // Stray requests and sequences cut short by a restart.
  task automatic send_noise();
    case ($urandom_range(4))
      0: send_byte(pick_byte());
      1: send_request(CMD_RESTART, pick_byte(), 7'($urandom_range(127)));
      2: send_request(CMD_IGNORED, pick_byte(), 7'($urandom_range(127)));
      3: send_request(CMD_LOAD, pick_byte(), 7'($urandom_range(127)));
      default: begin
        send_byte($urandom_range(1) ? OP_DELAY16 : pick_byte());
        send_request(CMD_RESTART, pick_byte(), 7'($urandom_range(127)));
      end
    endcase
  endtask

  task automatic old_format_sequence();
    int r;
    r = $urandom_range(99);
    if (r < 10) begin
      send_noise();
    end else if (r < 22) begin
      send_byte(OP_DELAY8);
      send_byte(pick_byte());
    end else if (r < 34) begin
      send_byte(OP_DELAY16);
      send_byte(pick_byte());
      send_byte(pick_byte());
    end else if (r < 44) begin
      send_byte($urandom_range(1) ? OP_CHIP_HI : OP_CHIP_LO);
    end else if (r < 54) begin
      send_byte(OP_ESCAPE);
      send_byte(pick_byte());
      send_byte(pick_byte());
    end else begin
      send_byte($urandom_range(3) == 0 ? pick_byte() : 8'($urandom_range(255, 5)));
      send_byte(pick_byte());
    end
  endtask

  task automatic new_format_sequence();
    int r;
    int span;
    logic [7:0] code;
    r = $urandom_range(99);
    if (r < 10) begin
      send_noise();
    end else if (r < 25) begin
      send_byte(sb.short_code);
      send_byte(pick_byte());
    end else if (r < 40) begin
      send_byte(sb.long_code);
      send_byte(pick_byte());
    end else begin
      span = (sb.map_len > CM_DEPTH) ? CM_DEPTH : int'(sb.map_len);
      code = pick_byte();
      // Lean toward registers that go through the codemap.
      if (span > 0 && $urandom_range(99) < 60) code[6:0] = 7'($urandom_range(span - 1));
      send_byte(code);
      send_byte(pick_byte());
    end
  endtask

  initial begin
    logic [7:0] sc;
    logic [7:0] lc;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_FORMAT;
    cfg_data = '0;
    stream_if.valid = 1'b0;
    stream_if.command = CMD_BYTE;
    stream_if.data_byte = '0;
    stream_if.table_index = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 27;
    snk_idle_pct = 46;

    // The codemap is undefined after reset, so fill every entry first.
    for (int i = 0; i < CM_DEPTH; i++) send_request(CMD_LOAD, pick_byte(), 7'(i));

    // Old format on a single OPL2.
    send_byte(OP_DELAY8);
    send_byte(8'hFF);
    send_byte(OP_DELAY16);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(OP_DELAY16);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(OP_CHIP_LO);
    send_byte(8'h80);
    send_byte(OP_ESCAPE);
    send_byte(8'h01);
    send_byte(8'h7F);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(OP_DELAY16);
    send_byte(8'h12);
    send_request(CMD_RESTART, 8'h00, 7'd0);
    send_request(CMD_IGNORED, 8'hFF, 7'h7F);
    drain();

    // Unknown hardware drops the write, but the chip select still sticks.
    write_setting(CFG_HARDWARE, 8'd255);
    send_byte(OP_CHIP_HI);
    send_byte(8'h20);
    send_byte(8'h33);
    drain();
    write_setting(CFG_HARDWARE, HW_OPL3);
    send_byte(8'h40);
    send_byte(8'h44);

    // Leave an old-format item half done, then switch to the new format.
    send_byte(8'h20);
    drain();
    write_setting(CFG_FORMAT, 8'd1);
    write_setting(CFG_CM_LENGTH, 8'd4);
    send_byte(8'h83);
    send_byte(8'h99);
    send_byte(sb.short_code);
    send_byte(8'h00);
    send_byte(sb.long_code);
    send_byte(8'hFF);
    drain();

    for (int p = 0; p < 12; p++) begin
      if (p == 4) begin
        src_idle_pct = 46;
        snk_idle_pct = 27;
      end else if (p == 8) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      sc = 8'($urandom_range(255));
      lc = 8'($urandom_range(255));
      if (p == 0) begin
        sc = 8'h00;
        lc = 8'h01;
      end else if (p == 3) begin
        sc = 8'hFF;
        lc = 8'hFE;
      end else if (p == 5) begin
        sc = 8'h80;
        lc = 8'h80;
      end
      apply_settings(p[0], phase_hw[p], sc, lc, phase_len[p]);
      if (p == 1 || p == 8) stall_asks <= stall_asks + 1;
      requests_sent = 0;
      while (requests_sent < 65) begin
        if (p[0]) new_format_sequence();
        else old_format_sequence();
      end
      // Sometimes leave an item open across the next settings change.
      if ($urandom_range(1)) send_byte(pick_byte());
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
